[rtl/qrs_pkg.sv]
// Shared widths, request and result types, status codes and helpers of the root solver.
`default_nettype none

package qrs_pkg;

  // Coefficient and root word format.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // The square root takes one result bit a step from a discriminant of 2W+2 bits.
  localparam int SQ_STEPS = WORD_BITS + 1;
  localparam int SQ_IN_W  = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SQ_REM_W = ROOT_W + 3;

  // Numerator, its magnitude, the scaled dividend and the divisor.
  localparam int NUMER_W  = ROOT_W + 2;
  localparam int MAG_W    = ROOT_W + 1;
  localparam int DIVN_W   = MAG_W + FRAC_BITS;
  localparam int DEN_W    = WORD_BITS + 1;
  localparam int DV_STEPS = DIVN_W;
  localparam int QUO_W    = DIVN_W;

  // Status codes of a result.
  localparam logic [1:0] ST_REAL    = 2'd0;
  localparam logic [1:0] ST_NO_REAL = 2'd1;
  localparam logic [1:0] ST_A_ZERO  = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] root_plus;
    logic signed [WORD_BITS-1:0] root_minus;
    logic [1:0]                  status;
    logic                        saturated;
  } rsp_t;

  // Data that travels alongside the square root pipeline.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic [1:0]                  status;
  } sq_side_t;

  // Data that travels alongside the divider pipeline.
  typedef struct packed {
    logic [1:0] neg;
    logic [1:0] status;
  } dv_side_t;

  // Magnitude of a signed word as an unsigned word.
  function automatic logic [WORD_BITS-1:0] word_mag(input logic [WORD_BITS-1:0] v);
    word_mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

[rtl/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
`default_nettype none

module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        src_valid,
  input  logic [qrs_pkg::SQ_IN_W-1:0] src_d,
  input  qrs_pkg::sq_side_t           src_side,
  output logic                        dst_valid,
  output logic [qrs_pkg::ROOT_W-1:0]  dst_root,
  output qrs_pkg::sq_side_t           dst_side
);

  logic                          vld  [qrs_pkg::SQ_STEPS];
  logic [qrs_pkg::SQ_REM_W-1:0]  rem  [qrs_pkg::SQ_STEPS];
  logic [qrs_pkg::ROOT_W-1:0]    root [qrs_pkg::SQ_STEPS];
  logic [qrs_pkg::SQ_IN_W-1:0]   dsh  [qrs_pkg::SQ_STEPS];
  qrs_pkg::sq_side_t             side [qrs_pkg::SQ_STEPS];

  for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_step
    logic                         p_vld;
    logic [qrs_pkg::SQ_REM_W-1:0] p_rem;
    logic [qrs_pkg::ROOT_W-1:0]   p_root;
    logic [qrs_pkg::SQ_IN_W-1:0]  p_d;
    qrs_pkg::sq_side_t            p_side;
    logic [qrs_pkg::SQ_REM_W-1:0] r2;
    logic [qrs_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    // The first stage starts from the incoming discriminant.
    if (k == 0) begin : g_first
      assign p_vld  = src_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_d    = src_d;
      assign p_side = src_side;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
      assign p_d    = dsh[k-1];
      assign p_side = side[k-1];
    end

    // Bring down two bits and try the next root bit.
    assign r2    = {p_rem[qrs_pkg::SQ_REM_W-3:0], p_d[qrs_pkg::SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]  <= ge ? (r2 - trial) : r2;
        root[k] <= {p_root[qrs_pkg::ROOT_W-2:0], ge};
        dsh[k]  <= {p_d[qrs_pkg::SQ_IN_W-3:0], 2'b00};
        side[k] <= p_side;
      end
    end
  end

  assign dst_valid = vld[qrs_pkg::SQ_STEPS-1];
  assign dst_root  = root[qrs_pkg::SQ_STEPS-1];
  assign dst_side  = side[qrs_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

[rtl/qrs_div.sv]
// Pipelined two-lane restoring divider, one quotient bit per register stage.
`default_nettype none

module qrs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       src_valid,
  input  logic [qrs_pkg::DIVN_W-1:0] src_num_p,
  input  logic [qrs_pkg::DIVN_W-1:0] src_num_m,
  input  logic [qrs_pkg::DEN_W-1:0]  src_den,
  input  qrs_pkg::dv_side_t          src_side,
  output logic                       dst_valid,
  output logic [qrs_pkg::QUO_W-1:0]  dst_q_p,
  output logic [qrs_pkg::QUO_W-1:0]  dst_q_m,
  output qrs_pkg::dv_side_t          dst_side
);

  logic                        vld   [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DEN_W-1:0]   rem_p [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DEN_W-1:0]   rem_m [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DIVN_W-1:0]  num_p [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DIVN_W-1:0]  num_m [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::QUO_W-1:0]   q_p   [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::QUO_W-1:0]   q_m   [qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DEN_W-1:0]   den   [qrs_pkg::DV_STEPS];
  qrs_pkg::dv_side_t           side  [qrs_pkg::DV_STEPS];

  for (genvar k = 0; k < qrs_pkg::DV_STEPS; k++) begin : g_step
    logic                       p_vld;
    logic [qrs_pkg::DEN_W-1:0]  p_rem_p, p_rem_m, p_den;
    logic [qrs_pkg::DIVN_W-1:0] p_num_p, p_num_m;
    logic [qrs_pkg::QUO_W-1:0]  p_q_p, p_q_m;
    qrs_pkg::dv_side_t          p_side;
    logic [qrs_pkg::DEN_W:0]    r_p, r_m, den_x;
    logic                       ge_p, ge_m;

    if (k == 0) begin : g_first
      assign p_vld   = src_valid;
      assign p_rem_p = '0;
      assign p_rem_m = '0;
      assign p_num_p = src_num_p;
      assign p_num_m = src_num_m;
      assign p_q_p   = '0;
      assign p_q_m   = '0;
      assign p_den   = src_den;
      assign p_side  = src_side;
    end else begin : g_next
      assign p_vld   = vld[k-1];
      assign p_rem_p = rem_p[k-1];
      assign p_rem_m = rem_m[k-1];
      assign p_num_p = num_p[k-1];
      assign p_num_m = num_m[k-1];
      assign p_q_p   = q_p[k-1];
      assign p_q_m   = q_m[k-1];
      assign p_den   = den[k-1];
      assign p_side  = side[k-1];
    end

    // Shift in the next dividend bit and subtract where the divisor fits.
    assign den_x = {1'b0, p_den};
    assign r_p   = {p_rem_p, p_num_p[qrs_pkg::DIVN_W-1]};
    assign r_m   = {p_rem_m, p_num_m[qrs_pkg::DIVN_W-1]};
    assign ge_p  = (r_p >= den_x);
    assign ge_m  = (r_m >= den_x);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_p[k] <= qrs_pkg::DEN_W'(ge_p ? (r_p - den_x) : r_p);
        rem_m[k] <= qrs_pkg::DEN_W'(ge_m ? (r_m - den_x) : r_m);
        num_p[k] <= {p_num_p[qrs_pkg::DIVN_W-2:0], 1'b0};
        num_m[k] <= {p_num_m[qrs_pkg::DIVN_W-2:0], 1'b0};
        q_p[k]   <= {p_q_p[qrs_pkg::QUO_W-2:0], ge_p};
        q_m[k]   <= {p_q_m[qrs_pkg::QUO_W-2:0], ge_m};
        den[k]   <= p_den;
        side[k]  <= p_side;
      end
    end
  end

  assign dst_valid = vld[qrs_pkg::DV_STEPS-1];
  assign dst_q_p   = q_p[qrs_pkg::DV_STEPS-1];
  assign dst_q_m   = q_m[qrs_pkg::DV_STEPS-1];
  assign dst_side  = side[qrs_pkg::DV_STEPS-1];

endmodule

`default_nettype wire

[rtl/quadratic_root_solver_top.sv]
// Top level of the fixed-point quadratic root solver.
//
// Takes the Q16.16 coefficients a, b and c of one quadratic per request and returns
// both real roots in Q16.16, rounded toward zero, with a status code and a saturation
// flag. The block is a single stall-controlled pipeline: it accepts one request every
// cycle while req_stall is low, and each result passes through one multiply stage, one
// discriminant stage, 33 square root stages, one numerator stage, 50 divider stages
// and the output register. The depth is set by the bit-per-stage square root and
// division. While a result waits at the output the whole pipeline holds and req_stall
// is raised; nothing is lost or repeated.
`default_nettype none

module quadratic_root_solver_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qrs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qrs_pkg::rsp_t rsp
);

  localparam int W  = qrs_pkg::WORD_BITS;
  localparam int PW = 2 * W;

  logic adv;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  // Multiply stage: b squared and the magnitude of a times c.
  logic [W-1:0]        mag_a, mag_b, mag_c;
  logic                m_valid;
  logic [PW-1:0]       m_bb, m_ac;
  logic                m_ac_neg, m_a_zero;
  logic signed [W-1:0] m_a, m_b;

  assign mag_a = qrs_pkg::word_mag(req.coef_a);
  assign mag_b = qrs_pkg::word_mag(req.coef_b);
  assign mag_c = qrs_pkg::word_mag(req.coef_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_bb     <= PW'(mag_b) * PW'(mag_b);
      m_ac     <= PW'(mag_a) * PW'(mag_c);
      m_ac_neg <= (req.coef_c != '0) && (req.coef_a[W-1] != req.coef_c[W-1]);
      m_a_zero <= (req.coef_a == '0);
      m_a      <= req.coef_a;
      m_b      <= req.coef_b;
    end
  end

  // Discriminant stage: b*b - 4ac as a magnitude, with its sign turned into status.
  logic [qrs_pkg::SQ_IN_W-1:0] bb_x, ac4, d_next;
  logic [1:0]                  st_next;
  logic                        d_valid;
  logic [qrs_pkg::SQ_IN_W-1:0] d_val;
  qrs_pkg::sq_side_t           d_side;

  assign bb_x   = {2'b00, m_bb};
  assign ac4    = {m_ac, 2'b00};
  assign d_next = m_ac_neg ? (bb_x + ac4) : (bb_x - ac4);

  always_comb begin
    if (m_a_zero) begin
      st_next = qrs_pkg::ST_A_ZERO;
    end else if (!m_ac_neg && (bb_x < ac4)) begin
      st_next = qrs_pkg::ST_NO_REAL;
    end else begin
      st_next = qrs_pkg::ST_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_val         <= d_next;
      d_side.a      <= m_a;
      d_side.b      <= m_b;
      d_side.status <= st_next;
    end
  end

  // Square root of the discriminant.
  logic                       s_valid;
  logic [qrs_pkg::ROOT_W-1:0] s_root;
  qrs_pkg::sq_side_t          s_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .src_valid (d_valid),
    .src_d     (d_val),
    .src_side  (d_side),
    .dst_valid (s_valid),
    .dst_root  (s_root),
    .dst_side  (s_side)
  );

  // Numerator stage: -b plus and minus the root, split into sign and magnitude.
  logic signed [qrs_pkg::NUMER_W-1:0] b_x, s_x, np, nm;
  logic [qrs_pkg::NUMER_W-1:0]        np_mag, nm_mag;
  logic                               n_valid;
  logic [qrs_pkg::DIVN_W-1:0]         n_num_p, n_num_m;
  logic [qrs_pkg::DEN_W-1:0]          n_den;
  qrs_pkg::dv_side_t                  n_side;

  assign b_x    = qrs_pkg::NUMER_W'(s_side.b);
  assign s_x    = $signed({2'b00, s_root});
  assign np     = s_x - b_x;
  assign nm     = -b_x - s_x;
  assign np_mag = np[qrs_pkg::NUMER_W-1] ? -np : np;
  assign nm_mag = nm[qrs_pkg::NUMER_W-1] ? -nm : nm;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (adv) begin
      n_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_num_p       <= {np_mag[qrs_pkg::MAG_W-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
      n_num_m       <= {nm_mag[qrs_pkg::MAG_W-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
      n_den         <= {qrs_pkg::word_mag(s_side.a), 1'b0};
      n_side.neg    <= {np[qrs_pkg::NUMER_W-1] ^ s_side.a[W-1],
                        nm[qrs_pkg::NUMER_W-1] ^ s_side.a[W-1]};
      n_side.status <= s_side.status;
    end
  end

  // Both divisions by 2a.
  logic                      q_valid;
  logic [qrs_pkg::QUO_W-1:0] q_p, q_m;
  qrs_pkg::dv_side_t         q_side;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .src_valid (n_valid),
    .src_num_p (n_num_p),
    .src_num_m (n_num_m),
    .src_den   (n_den),
    .src_side  (n_side),
    .dst_valid (q_valid),
    .dst_q_p   (q_p),
    .dst_q_m   (q_m),
    .dst_side  (q_side)
  );

  // Output stage: clamp each quotient to the word range and apply the sign.
  localparam logic [qrs_pkg::QUO_W-1:0] HALF = qrs_pkg::QUO_W'(1) << (W - 1);

  logic [qrs_pkg::QUO_W-1:0] lim_p, lim_m, v_p, v_m;
  logic                      over_p, over_m;
  logic [W-1:0]              r_p, r_m;
  logic                      real_roots;

  assign lim_p  = q_side.neg[1] ? HALF : (HALF - 1'b1);
  assign lim_m  = q_side.neg[0] ? HALF : (HALF - 1'b1);
  assign over_p = (q_p > lim_p);
  assign over_m = (q_m > lim_m);
  assign v_p    = over_p ? lim_p : q_p;
  assign v_m    = over_m ? lim_m : q_m;
  assign r_p    = q_side.neg[1] ? -v_p[W-1:0] : v_p[W-1:0];
  assign r_m    = q_side.neg[0] ? -v_m[W-1:0] : v_m[W-1:0];
  assign real_roots = (q_side.status == qrs_pkg::ST_REAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.root_plus  <= real_roots ? r_p : '0;
      rsp.root_minus <= real_roots ? r_m : '0;
      rsp.status     <= q_side.status;
      rsp.saturated  <= real_roots && (over_p || over_m);
    end
  end

endmodule

`default_nettype wire
